### rtl/core/dpc_pkg.sv
`timescale 1ns / 1ps

package dpc_pkg;

    localparam logic [23:0] BIT_TOTAL_MAX = 24'hFF_FFFF;
    localparam int          BURST_MAX     = 3;

    // Class prefixes
    localparam logic [1:0] PFX_MID   = 2'b10;
    localparam logic [2:0] PFX_HIGH  = 3'b110;
    localparam logic [2:0] PFX_LARGE = 3'b111;

    // Class lower bounds
    localparam logic [8:0] MAG_MID   = 9'd2;
    localparam logic [8:0] MAG_HIGH  = 9'd6;
    localparam logic [8:0] MAG_LARGE = 9'd22;

    // Code lengths
    localparam logic [3:0] LEN_SMALL = 4'd3;
    localparam logic [3:0] LEN_MID   = 4'd5;
    localparam logic [3:0] LEN_HIGH  = 4'd8;
    localparam logic [3:0] LEN_LARGE = 4'd12;

    typedef struct packed {
        logic [11:0] bits;   // right aligned, earliest bit highest
        logic [3:0]  len;
    } t_code;

    // Bytes produced by one word, handed from packer to output buffer
    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] bytes;   // bytes[0] goes out first
        logic [1:0]                n;
        logic                      last_flag;
        logic [23:0]               total;
    } t_burst;

    // Prefix code of one difference: class prefix, offset bits, sign
    function automatic t_code make_code(logic [8:0] diff);
        logic       neg;
        logic [8:0] mag;
        logic [8:0] off;
        t_code      c;
        neg = diff[8];
        mag = neg ? 9'(~diff + 9'd1) : diff;   // -256 gives 256
        c   = '0;
        if (mag < MAG_MID) begin
            c.bits = {9'b0, 1'b0, mag[0], neg};
            c.len  = LEN_SMALL;
        end else if (mag < MAG_HIGH) begin
            off    = mag - MAG_MID;
            c.bits = {7'b0, PFX_MID, off[1:0], neg};
            c.len  = LEN_MID;
        end else if (mag < MAG_LARGE) begin
            off    = mag - MAG_HIGH;
            c.bits = {4'b0, PFX_HIGH, off[3:0], neg};
            c.len  = LEN_HIGH;
        end else begin
            off    = mag - MAG_LARGE;
            c.bits = {PFX_LARGE, off[7:0], neg};
            c.len  = LEN_LARGE;
        end
        return c;
    endfunction

endpackage

### rtl/core/dpc_packer.sv
`timescale 1ns / 1ps

module dpc_packer import dpc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [8:0]   i_diff,
    input  logic         i_last,
    input  logic         i_room,
    output logic         o_take,
    output t_burst       o_burst
);

    logic [6:0]  r_pbits, n_pbits;
    logic [2:0]  r_pcnt,  n_pcnt;
    logic [23:0] r_total, n_total;

    t_code       code;
    logic [18:0] acc;
    logic [4:0]  cnt;
    logic [4:0]  sh;
    logic [23:0] al;
    logic [1:0]  nfull;
    logic [2:0]  rem;
    logic [6:0]  rem_mask;

    assign o_take = i_valid && i_room;

    // Code, append to held bits, left align for byte slicing
    always_comb begin
        code     = make_code(i_diff);
        acc      = 19'({12'b0, r_pbits} << code.len) | {7'b0, code.bits};
        cnt      = {2'b0, r_pcnt} + {1'b0, code.len};
        nfull    = cnt[4:3];
        rem      = cnt[2:0];
        sh       = 5'd24 - cnt;
        al       = {5'b0, acc} << sh;
        rem_mask = 7'((8'd1 << rem) - 8'd1);
    end

    // Saturating bit count
    always_comb begin
        if (r_total > BIT_TOTAL_MAX - {20'b0, code.len}) begin
            n_total = BIT_TOTAL_MAX;
        end else begin
            n_total = r_total + {20'b0, code.len};
        end
    end

    // Result burst: full bytes, plus a padded partial byte on the last word
    always_comb begin
        o_burst.bytes[0]  = al[23:16];
        o_burst.bytes[1]  = al[15:8];
        o_burst.bytes[2]  = al[7:0];
        o_burst.n         = nfull + {1'b0, (i_last && rem != 3'd0)};
        o_burst.last_flag = i_last;
        o_burst.total     = n_total;
        n_pbits           = acc[6:0] & rem_mask;
        n_pcnt            = rem;
    end

    // Held state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pbits <= '0;
            r_pcnt  <= '0;
            r_total <= '0;
        end else if (o_take) begin
            if (i_last) begin
                r_pbits <= '0;
                r_pcnt  <= '0;
                r_total <= '0;
            end else begin
                r_pbits <= n_pbits;
                r_pcnt  <= n_pcnt;
                r_total <= n_total;
            end
        end
    end

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && i_last |=> r_pcnt == 3'd0 && r_pbits == 7'd0 && r_total == 24'd0)
        else $error("stream state not cleared after last word");

    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && i_last |-> o_burst.n != 2'd0)
        else $error("last word produced no byte");

    a_total_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> o_burst.total >= r_total)
        else $error("bit total went backwards");

    a_held_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_pbits} >> r_pcnt) == 8'd0)
        else $error("held bits above count not zero");

endmodule

### rtl/core/dpc_out_buf.sv
`timescale 1ns / 1ps

module dpc_out_buf import dpc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_load,
    input  t_burst       i_burst,
    input  logic         i_stall,
    output logic         o_room,
    output logic         o_valid,
    output logic [7:0]   o_out_byte,
    output logic         o_final_byte,
    output logic [23:0]  o_bit_total
);

    logic [BURST_MAX-1:0][7:0] r_bytes;
    logic [1:0]                r_left;
    logic                      r_last;
    logic [23:0]               r_total;
    logic                      take;

    assign take         = o_valid && !i_stall;
    assign o_valid      = r_left != 2'd0;
    assign o_room       = (r_left == 2'd0) || (r_left == 2'd1 && take);
    assign o_out_byte   = r_bytes[0];
    assign o_final_byte = r_last && r_left == 2'd1;
    assign o_bit_total  = r_total;

    // Control: bytes remaining
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_load) begin
            r_left <= i_burst.n;
        end else if (take) begin
            r_left <= r_left - 2'd1;
        end
    end

    // Payload: load a burst or shift one byte out
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_burst.bytes;
            r_last  <= i_burst.last_flag;
            r_total <= i_burst.total;
        end else if (take) begin
            r_bytes <= {8'b0, r_bytes[BURST_MAX-1:1]};
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> r_left == 2'd0 || (r_left == 2'd1 && !i_stall))
        else $error("burst loaded over undelivered bytes");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && !i_load |=> r_left == $past(r_left) - 2'd1)
        else $error("byte count did not drop on delivery");

    a_final_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_final_byte && take && !i_load |=> !o_valid)
        else $error("bytes left after final byte");

endmodule

### rtl/core/difference_prefix_code_encoder.sv
`timescale 1ns / 1ps

// Prefix-code encoder for signed pixel differences, packed MSB-first into bytes.
// Input channel: i_valid / o_stall with i_difference and i_last_item; a word
// is taken at a clock edge where i_valid is high and o_stall is low.
// Output channel: o_valid / i_stall with o_out_byte, o_final_byte and
// o_bit_total; a byte is delivered at an edge where o_valid is high and
// i_stall is low. Each difference makes 3 to 12 code bits, so a word yields
// zero, one or two bytes, and a word marked last_item also flushes a partial
// byte padded with zeros; o_final_byte marks the last byte of the stream.
// A word is registered in the input register at acceptance; its bytes are then loaded
// into the output buffer once it has room, and are shown from there one at a time.
// Throughput is set by that buffer: one word per cycle while words yield at most
// one byte and i_stall stays low; otherwise a word waits for the bytes before it.
// o_stall goes high while the input register holds a word whose bytes cannot
// yet enter the output buffer; a stalled output byte holds steady.
// Reset (synchronous, active low) empties both registers and clears the held
// bits and the running bit count.

module difference_prefix_code_encoder import dpc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic signed [8:0] i_difference,
    input  logic              i_last_item,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_out_byte,
    output logic              o_final_byte,
    output logic [23:0]       o_bit_total
);

    logic        r_in_valid;
    logic [8:0]  r_diff;
    logic        r_last;
    logic        room;
    logic        take;
    logic        accept;
    t_burst      burst;

    assign o_stall = r_in_valid && !take;
    assign accept  = i_valid && !o_stall;

    // Input register: control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    // Input register: payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_diff <= i_difference;
            r_last <= i_last_item;
        end
    end

    dpc_packer u_packer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_diff  (r_diff),
        .i_last  (r_last),
        .i_room  (room),
        .o_take  (take),
        .o_burst (burst)
    );

    dpc_out_buf u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (take),
        .i_burst      (burst),
        .i_stall      (i_stall),
        .o_room       (room),
        .o_valid      (o_valid),
        .o_out_byte   (o_out_byte),
        .o_final_byte (o_final_byte),
        .o_bit_total  (o_bit_total)
    );

endmodule
